// ----- hdl/otl_pkg.sv -----
// Shared types and codes for the ordered tagged list with cursor.
// No dependencies; imported by the interfaces, otl_ctrl, the top level and the testbench.
package otl_pkg;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_READ     = 3'd2,
    ACT_HOME     = 3'd3,
    ACT_STEP     = 3'd4,
    ACT_SEEK_FWD = 3'd5,
    ACT_SEEK_BWD = 3'd6
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOMATCH  = 3'd3,
    ST_NOCURSOR = 3'd4
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_PUT,
    S_FETCH,
    S_LOAD,
    S_FIN
  } state_t;

endpackage

// ----- hdl/otl_if.sv -----
// Request and response channel interfaces (valid/ready words).
// Depends on otl_pkg for field widths.
interface otl_req_if #(
  parameter int PAYLOAD_WIDTH = 16,
  parameter int COLOR_WIDTH   = 3
);
  import otl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic [POS_W-1:0]         position;
  logic [PAYLOAD_WIDTH-1:0] cell_payload;
  logic [COLOR_WIDTH-1:0]   cell_color;
  logic [COLOR_WIDTH-1:0]   target_color;
  logic                     move_cursor;

  modport source (output valid, action, position, cell_payload, cell_color,
                  target_color, move_cursor, input ready);
  modport sink   (input valid, action, position, cell_payload, cell_color,
                  target_color, move_cursor, output ready);
endinterface

interface otl_rsp_if #(
  parameter int PAYLOAD_WIDTH = 16,
  parameter int COLOR_WIDTH   = 3
);
  import otl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [PAYLOAD_WIDTH-1:0] read_payload;
  logic [COLOR_WIDTH-1:0]   read_color;
  logic [COUNT_W-1:0]       count_now;
  logic [COUNT_W-1:0]       cursor_at;
  logic                     at_last;
  logic                     found;

  modport source (output valid, status, read_payload, read_color, count_now,
                  cursor_at, at_last, found, input ready);
  modport sink   (input valid, status, read_payload, read_color, count_now,
                  cursor_at, at_last, found, output ready);
endinterface

// ----- hdl/otl_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module otl_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/otl_ctrl.sv -----
// Sequencer for the list: decodes a request, walks the cell RAM to shift or
// scan, then fetches the shown cell. Depends on otl_pkg and otl_req_if.
module otl_ctrl #(
  parameter int CAPACITY      = 64,
  parameter int PAYLOAD_WIDTH = 16,
  parameter int COLOR_WIDTH   = 3
) (
  input  logic                                   clk,
  input  logic                                   rst,
  otl_req_if.sink                                req,
  output logic                                   ram_wr_en,
  output logic [$clog2(CAPACITY)-1:0]            ram_wr_addr,
  output logic [PAYLOAD_WIDTH+COLOR_WIDTH-1:0]   ram_wr_data,
  output logic                                   ram_rd_en,
  output logic [$clog2(CAPACITY)-1:0]            ram_rd_addr,
  input  logic [PAYLOAD_WIDTH+COLOR_WIDTH-1:0]   ram_rd_data,
  output logic                                   res_valid,
  input  logic                                   res_free,
  output logic [otl_pkg::STATUS_W-1:0]           res_status,
  output logic [PAYLOAD_WIDTH-1:0]               res_payload,
  output logic [COLOR_WIDTH-1:0]                 res_color,
  output logic [otl_pkg::COUNT_W-1:0]            res_count,
  output logic [otl_pkg::COUNT_W-1:0]            res_cursor,
  output logic                                   res_at_last,
  output logic                                   res_found
);
  import otl_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;
  localparam int DW   = PAYLOAD_WIDTH + COLOR_WIDTH;

  state_t                   state, state_next;
  logic [CNTW-1:0]          cnt, cnt_next;
  logic [CNTW-1:0]          cur, cur_next;
  act_t                     act, act_next;
  stat_t                    status, status_next;
  logic                     found, found_next;
  logic [CNTW-1:0]          ptr, ptr_next;
  logic [CNTW-1:0]          remain, remain_next;
  logic                     pend, pend_next;
  logic [AW-1:0]            pend_addr, pend_addr_next;
  logic [DW-1:0]            new_item, new_item_next;
  logic [AW-1:0]            put_addr, put_addr_next;
  logic [COLOR_WIDTH-1:0]   tgt, tgt_next;
  logic                     move, move_next;
  logic                     fetch_read, fetch_read_next;
  logic [AW-1:0]            fetch_addr, fetch_addr_next;
  logic [PAYLOAD_WIDTH-1:0] rp, rp_next;
  logic [COLOR_WIDTH-1:0]   rc, rc_next;

  logic [CMPW-1:0] pos_c, cnt_c, cur_c;
  logic            ins_ok, pos_ok, fwd, seek;

  assign pos_c  = CMPW'(req.position);
  assign cnt_c  = CMPW'(cnt);
  assign cur_c  = CMPW'(cur);
  assign ins_ok = (pos_c != '0) && (pos_c <= cnt_c + 1'b1);
  assign pos_ok = (pos_c != '0) && (pos_c <= cnt_c);
  assign fwd    = (act == ACT_REMOVE) || (act == ACT_SEEK_FWD);
  assign seek   = (act == ACT_SEEK_FWD) || (act == ACT_SEEK_BWD);

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      cur   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      cur   <= cur_next;
      pend  <= pend_next;
    end
    act        <= act_next;
    status     <= status_next;
    found      <= found_next;
    ptr        <= ptr_next;
    remain     <= remain_next;
    pend_addr  <= pend_addr_next;
    new_item   <= new_item_next;
    put_addr   <= put_addr_next;
    tgt        <= tgt_next;
    move       <= move_next;
    fetch_read <= fetch_read_next;
    fetch_addr <= fetch_addr_next;
    rp         <= rp_next;
    rc         <= rc_next;
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cur_next        = cur;
    act_next        = act;
    status_next     = status;
    found_next      = found;
    ptr_next        = ptr;
    remain_next     = remain;
    pend_next       = pend;
    pend_addr_next  = pend_addr;
    new_item_next   = new_item;
    put_addr_next   = put_addr;
    tgt_next        = tgt;
    move_next       = move;
    fetch_read_next = fetch_read;
    fetch_addr_next = fetch_addr;
    rp_next         = rp;
    rc_next         = rc;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = '0;
    ram_wr_data     = '0;
    ram_rd_en       = 1'b0;
    ram_rd_addr     = '0;
    res_valid       = 1'b0;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          act_next        = act_t'(req.action);
          status_next     = ST_OK;
          found_next      = 1'b0;
          fetch_read_next = 1'b0;
          tgt_next        = req.target_color;
          move_next       = req.move_cursor;
          new_item_next   = {req.cell_payload, req.cell_color};
          pend_next       = 1'b0;
          state_next      = S_FETCH;
          case (act_t'(req.action))
            ACT_INSERT: begin
              if (!ins_ok) begin
                status_next = ST_BADPOS;
              end else if (cnt_c == CMPW'(CAPACITY)) begin
                status_next = ST_FULL;
              end else begin
                cnt_next = cnt + 1'b1;
                if (cur != '0 && cur_c >= pos_c) begin
                  cur_next = cur + 1'b1;
                end
                // shift cells pos-1..cnt-1 up by one, top first
                ptr_next      = cnt - 1'b1;
                remain_next   = CNTW'(cnt_c - pos_c + 1'b1);
                put_addr_next = AW'(pos_c - 1'b1);
                state_next    = S_WALK;
              end
            end
            ACT_REMOVE: begin
              if (!pos_ok) begin
                status_next = ST_BADPOS;
              end else begin
                cnt_next = cnt - 1'b1;
                if (cur_c == pos_c) begin
                  cur_next = '0;
                end else if (cur_c > pos_c) begin
                  cur_next = cur - 1'b1;
                end
                ptr_next    = CNTW'(pos_c);
                remain_next = CNTW'(cnt_c - pos_c);
                state_next  = S_WALK;
              end
            end
            ACT_READ: begin
              if (!pos_ok) begin
                status_next = ST_BADPOS;
              end else begin
                fetch_read_next = 1'b1;
                fetch_addr_next = AW'(pos_c - 1'b1);
              end
            end
            ACT_HOME: begin
              if (cnt == '0) begin
                cur_next    = '0;
                status_next = ST_NOCURSOR;
              end else begin
                cur_next = CNTW'(1);
              end
            end
            ACT_STEP: begin
              if (cur == '0) begin
                status_next = ST_NOCURSOR;
              end else if (cur < cnt) begin
                cur_next = cur + 1'b1;
              end else begin
                cur_next    = '0;
                status_next = ST_NOMATCH;
              end
            end
            ACT_SEEK_FWD: begin
              if (cur == '0) begin
                status_next = ST_NOCURSOR;
              end else begin
                ptr_next    = cur;
                remain_next = cnt - cur;
                state_next  = S_WALK;
              end
            end
            ACT_SEEK_BWD: begin
              if (cur == '0) begin
                status_next = ST_NOCURSOR;
              end else begin
                ptr_next    = cur - 2'd2;
                remain_next = cur - 1'b1;
                state_next  = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        // read one cell a cycle; the word returned is handled in the cycle after its read
        if (remain != '0) begin
          ram_rd_en      = 1'b1;
          ram_rd_addr    = AW'(ptr);
          ptr_next       = fwd ? ptr + 1'b1 : ptr - 1'b1;
          remain_next    = remain - 1'b1;
          pend_next      = 1'b1;
          pend_addr_next = AW'(ptr);
        end else begin
          pend_next = 1'b0;
        end
        if (!seek) begin
          if (pend) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = (act == ACT_INSERT) ? pend_addr + 1'b1 : pend_addr - 1'b1;
            ram_wr_data = ram_rd_data;
          end
          if (remain == '0) begin
            state_next = (act == ACT_INSERT) ? S_PUT : S_FETCH;
          end
        end else begin
          if (pend && ram_rd_data[COLOR_WIDTH-1:0] == tgt) begin
            found_next = 1'b1;
            if (move) begin
              cur_next = CNTW'(pend_addr) + 1'b1;
            end
            pend_next  = 1'b0;
            state_next = S_FETCH;
          end else if (remain == '0 && !pend) begin
            status_next = ST_NOMATCH;
            if (move) begin
              cur_next = '0;
            end
            state_next = S_FETCH;
          end
        end
      end

      S_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = put_addr;
        ram_wr_data = new_item;
        state_next  = S_FETCH;
      end

      S_FETCH: begin
        if (fetch_read) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = fetch_addr;
          state_next  = S_LOAD;
        end else if (cur != '0) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = AW'(cur - 1'b1);
          state_next  = S_LOAD;
        end else begin
          rp_next    = '0;
          rc_next    = '0;
          state_next = S_FIN;
        end
      end

      S_LOAD: begin
        rp_next    = ram_rd_data[DW-1:COLOR_WIDTH];
        rc_next    = ram_rd_data[COLOR_WIDTH-1:0];
        state_next = S_FIN;
      end

      S_FIN: begin
        res_valid = 1'b1;
        if (res_free) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign res_status  = status;
  assign res_payload = rp;
  assign res_color   = rc;
  assign res_count   = COUNT_W'(cnt);
  assign res_cursor  = COUNT_W'(cur);
  assign res_at_last = (cur != '0) && (cur == cnt);
  assign res_found   = found;

endmodule

// ----- hdl/ordered_tagged_list_with_cursor_unit.sv -----
// Ordered tagged list with cursor: top level with cell RAM, sequencer and
// output register. Depends on otl_pkg, otl_if, otl_ram and otl_ctrl.
//
// Usage: one request word on req (action, position, payload, colors, move
// flag) gives exactly one response word on rsp. Both channels are
// valid/ready; a word moves when both are high at a clock edge.
// Cells live in one RAM of CAPACITY entries kept in list order.
// Steps from request to response; every action ends by fetching the shown
// cell (the read cell, else the cursor cell if there is one):
//   insert at p:  one RAM read per shifted cell, then the new cell is written
//   remove at p:  one RAM read per cell above p, each written one place down
//   seek:         one RAM read per cell scanned, stopping at the first match
//   others:       no walk; only the fetch
// The single RAM read port sets the pace: one cell per cycle. A new request
// is taken once the previous one has reached the output register.
// rst (synchronous) empties the list and clears the cursor; no RAM sweep.
// If rsp is stalled, one finished word waits in the output register and the
// next request is still taken and worked; it then holds until the slot frees.
module ordered_tagged_list_with_cursor_unit #(
  parameter int CAPACITY      = 64,
  parameter int PAYLOAD_WIDTH = 16,
  parameter int COLOR_WIDTH   = 3
) (
  input logic       clk,
  input logic       rst,
  otl_req_if.sink   req,
  otl_rsp_if.source rsp
);
  import otl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int DW = PAYLOAD_WIDTH + COLOR_WIDTH;

  logic                     ram_wr_en, ram_rd_en;
  logic [AW-1:0]            ram_wr_addr, ram_rd_addr;
  logic [DW-1:0]            ram_wr_data, ram_rd_data;
  logic                     res_valid, res_free;
  logic [STATUS_W-1:0]      res_status;
  logic [PAYLOAD_WIDTH-1:0] res_payload;
  logic [COLOR_WIDTH-1:0]   res_color;
  logic [COUNT_W-1:0]       res_count, res_cursor;
  logic                     res_at_last, res_found;

  otl_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  otl_ctrl #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .COLOR_WIDTH   (COLOR_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res_free    (res_free),
    .res_status  (res_status),
    .res_payload (res_payload),
    .res_color   (res_color),
    .res_count   (res_count),
    .res_cursor  (res_cursor),
    .res_at_last (res_at_last),
    .res_found   (res_found)
  );

  assign res_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_valid && res_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (res_valid && res_free) begin
      rsp.status       <= res_status;
      rsp.read_payload <= res_payload;
      rsp.read_color   <= res_color;
      rsp.count_now    <= res_count;
      rsp.cursor_at    <= res_cursor;
      rsp.at_last      <= res_at_last;
      rsp.found        <= res_found;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while sequencer busy");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.status == ST_OK)
    else $error("found set with error status");

  a_last_cursor: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.at_last |-> rsp.cursor_at != '0 && rsp.cursor_at == rsp.count_now)
    else $error("at_last without cursor on last cell");

  a_no_ram_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !ram_wr_en && !res_valid)
    else $error("RAM write or result while idle");
`endif

endmodule

// ----- tb/tb_ordered_tagged_list_with_cursor_unit.sv -----
// Testbench for the ordered tagged list with cursor: random and directed actions,
// checked against a built-in list predictor. Depends on otl_pkg, otl_if and the RTL.
module tb_ordered_tagged_list_with_cursor_unit;
  import otl_pkg::*;

  localparam int CAP = 64;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload;
    logic [2:0]  color;
    logic [6:0]  count;
    logic [6:0]  cursor;
    logic        last;
    logic        found;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  otl_req_if req ();
  otl_rsp_if rsp ();

  ordered_tagged_list_with_cursor_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] list_pay [CAP];
  logic [2:0]  list_col [CAP];
  int          list_len;
  int          cur_pos;
  rsp_t        pending [$];
  int          errors;
  int          idle_cycles;
  bit          hold_long;
  bit          stall_on;

  initial begin
    req.valid = 1'b0;
    req.action = '0;
    req.position = '0;
    req.cell_payload = '0;
    req.cell_color = '0;
    req.target_color = '0;
    req.move_cursor = 1'b0;
    rsp.ready = 1'b0;
  end

  function automatic rsp_t list_apply(logic [2:0] act, int pos, logic [15:0] pay,
                                      logic [2:0] col, logic [2:0] tgt, bit mv);
    rsp_t r;
    int hit;
    bit have_read;
    r = '0;
    have_read = 0;
    hit = 0;
    case (act)
      ACT_INSERT: begin
        if (pos < 1 || pos > list_len + 1) r.status = ST_BADPOS;
        else if (list_len >= CAP) r.status = ST_FULL;
        else begin
          for (int i = list_len; i >= pos; i--) begin
            list_pay[i] = list_pay[i-1];
            list_col[i] = list_col[i-1];
          end
          list_pay[pos-1] = pay;
          list_col[pos-1] = col;
          list_len++;
          if (cur_pos != 0 && cur_pos >= pos) cur_pos++;
        end
      end
      ACT_REMOVE: begin
        if (pos < 1 || pos > list_len) r.status = ST_BADPOS;
        else begin
          for (int i = pos; i < list_len; i++) begin
            list_pay[i-1] = list_pay[i];
            list_col[i-1] = list_col[i];
          end
          list_len--;
          if (cur_pos == pos) cur_pos = 0;
          else if (cur_pos > pos) cur_pos--;
        end
      end
      ACT_READ: begin
        if (pos < 1 || pos > list_len) r.status = ST_BADPOS;
        else begin
          r.payload = list_pay[pos-1];
          r.color = list_col[pos-1];
          have_read = 1;
        end
      end
      ACT_HOME: begin
        if (list_len == 0) begin
          cur_pos = 0;
          r.status = ST_NOCURSOR;
        end else cur_pos = 1;
      end
      ACT_STEP: begin
        if (cur_pos == 0) r.status = ST_NOCURSOR;
        else if (cur_pos < list_len) cur_pos++;
        else begin
          cur_pos = 0;
          r.status = ST_NOMATCH;
        end
      end
      ACT_SEEK_FWD, ACT_SEEK_BWD: begin
        if (cur_pos == 0 || cur_pos > list_len) r.status = ST_NOCURSOR;
        else begin
          if (act == ACT_SEEK_FWD) begin
            for (int i = cur_pos + 1; i <= list_len; i++)
              if (hit == 0 && list_col[i-1] == tgt) hit = i;
          end else begin
            for (int i = cur_pos - 1; i >= 1; i--)
              if (hit == 0 && list_col[i-1] == tgt) hit = i;
          end
          if (hit != 0) begin
            r.found = 1'b1;
            if (mv) cur_pos = hit;
          end else begin
            r.status = ST_NOMATCH;
            if (mv) cur_pos = 0;
          end
        end
      end
      default: ;
    endcase
    if (!have_read && cur_pos != 0 && cur_pos <= list_len) begin
      r.payload = list_pay[cur_pos-1];
      r.color = list_col[cur_pos-1];
    end
    r.count = list_len[6:0];
    r.cursor = cur_pos[6:0];
    r.last = (cur_pos != 0 && cur_pos == list_len);
    return r;
  endfunction

  // offers one word, holds it until taken, then predicts its response
  task automatic send_action(logic [2:0] act, int pos, logic [15:0] pay,
                             logic [2:0] col, logic [2:0] tgt, bit mv);
    req.valid <= 1'b1;
    req.action <= act;
    req.position <= pos[6:0];
    req.cell_payload <= pay;
    req.cell_color <= col;
    req.target_color <= tgt;
    req.move_cursor <= mv;
    do @(posedge clk); while (!req.ready);
    pending.push_back(list_apply(act, pos, pay, col, tgt, mv));
  endtask

  task automatic send_gap();
    int n;
    n = $urandom_range(0, 3);
    if (n == 0) return;
    req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_random(int n, int max_pos);
    logic [2:0] act;
    int pos;
    int burst;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      // favor inserts over removes so the list fills and seeks travel far
      case ($urandom_range(0, 9))
        0, 1, 2: act = ACT_INSERT;
        3, 4:    act = ACT_REMOVE;
        5:       act = ACT_READ;
        6:       act = ($urandom_range(0, 1)) ? ACT_HOME : ACT_STEP;
        7:       act = ACT_SEEK_FWD;
        8:       act = ACT_SEEK_BWD;
        default: act = 3'($urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 15) == 0) pos = $urandom_range(0, 127);
      else pos = $urandom_range(1, max_pos);
      send_action(act, pos, 16'($urandom), 3'($urandom), 3'($urandom), 1'($urandom));
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        send_gap();
      end else burst--;
    end
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
  endtask

  task automatic test_edges();
    send_action(ACT_HOME, 0, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_STEP, 0, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_SEEK_FWD, 0, 16'h0, 3'd0, 3'd1, 1'b1);
    send_action(ACT_READ, 1, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_REMOVE, 1, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_INSERT, 0, 16'h1234, 3'd1, 3'd0, 1'b0);
    send_action(ACT_INSERT, 2, 16'h1234, 3'd1, 3'd0, 1'b0);
    send_action(ACT_INSERT, 1, 16'hFFFF, 3'd7, 3'd0, 1'b0);
    send_action(ACT_INSERT, 2, 16'h0000, 3'd0, 3'd0, 1'b0);
    send_action(ACT_INSERT, 1, 16'hA5A5, 3'd2, 3'd0, 1'b0);
    send_action(ACT_HOME, 0, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_SEEK_FWD, 0, 16'h0, 3'd5, 3'd7, 1'b0);
    send_action(ACT_SEEK_FWD, 0, 16'h0, 3'd0, 3'd7, 1'b1);
    send_action(ACT_SEEK_BWD, 0, 16'h0, 3'd0, 3'd2, 1'b1);
    send_action(ACT_SEEK_BWD, 0, 16'h0, 3'd0, 3'd6, 1'b0);
    send_action(ACT_INSERT, 1, 16'h5A5A, 3'd4, 3'd0, 1'b0);
    send_action(ACT_STEP, 0, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_READ, 127, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_READ, 4, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(3'd7, 5, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_REMOVE, 1, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_SEEK_FWD, 0, 16'h0, 3'd0, 3'd3, 1'b1);
    send_action(ACT_STEP, 0, 16'h0, 3'd0, 3'd0, 1'b0);
    wait_drain();
  endtask

  // fills to capacity, overflows, steps off the end and removes the cursor cell
  task automatic test_full_list();
    while (list_len < CAP)
      send_action(ACT_INSERT, $urandom_range(1, list_len + 1), 16'($urandom),
                  3'($urandom), 3'd0, 1'b0);
    send_action(ACT_INSERT, CAP + 1, 16'h1, 3'd1, 3'd0, 1'b0);
    send_action(ACT_INSERT, 1, 16'h1, 3'd1, 3'd0, 1'b0);
    send_action(ACT_HOME, 0, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_SEEK_FWD, 0, 16'h0, 3'd0, 3'($urandom), 1'b1);
    send_action(ACT_REMOVE, cur_pos == 0 ? 1 : cur_pos, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_INSERT, list_len + 1, 16'h7, 3'd7, 3'd0, 1'b0);
    send_action(ACT_HOME, 0, 16'h0, 3'd0, 3'd0, 1'b0);
    for (int k = 0; k < CAP; k++) send_action(ACT_STEP, 0, 16'h0, 3'd0, 3'd0, 1'b0);
    send_action(ACT_READ, CAP, 16'h0, 3'd0, 3'd0, 1'b0);
    wait_drain();
  endtask

  // receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    hold_long = 1'b1;
    send_random(20, 8);
    wait_drain();
  endtask

  task automatic test_random();
    for (int k = 0; k < 14; k++) begin
      send_random(100, (k % 3 == 0) ? 70 : 12);
      if (k % 5 == 4) wait_drain();
    end
    wait_drain();
  endtask

  // response side: stall pattern, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_long) begin
      rsp.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 31) == 0) stall_on <= ~stall_on;
      rsp.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  initial begin
    stall_on = 1'b0;
    hold_long = 1'b0;
    wait (hold_long);
    repeat (400) @(posedge clk);
    hold_long = 1'b0;
  end

  always @(posedge clk) begin
    rsp_t got;
    rsp_t exp;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.status, rsp.read_payload, rsp.read_color, rsp.count_now,
             rsp.cursor_at, rsp.at_last, rsp.found};
      if (pending.size() == 0) begin
        $error("response word with none expected");
        errors++;
      end else begin
        exp = pending.pop_front();
        if (got.status !== exp.status) begin
          $error("status exp %0d got %0d", exp.status, got.status); errors++;
        end
        if (got.payload !== exp.payload) begin
          $error("read_payload exp %h got %h", exp.payload, got.payload); errors++;
        end
        if (got.color !== exp.color) begin
          $error("read_color exp %0d got %0d", exp.color, got.color); errors++;
        end
        if (got.count !== exp.count) begin
          $error("count_now exp %0d got %0d", exp.count, got.count); errors++;
        end
        if (got.cursor !== exp.cursor) begin
          $error("cursor_at exp %0d got %0d", exp.cursor, got.cursor); errors++;
        end
        if (got.last !== exp.last) begin
          $error("at_last exp %0d got %0d", exp.last, got.last); errors++;
        end
        if (got.found !== exp.found) begin
          $error("found exp %0d got %0d", exp.found, got.found); errors++;
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    list_len = 0;
    cur_pos = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edges();
    test_full_list();
    test_backpressure();
    test_random();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
